@@ src/bdef_pkg.sv @@
package bdef_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CHANNELS    = 3;

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int LOST_W   = $clog2(CHANNELS + 1);
    localparam int TIME_W   = 32;
    localparam int PIN_W    = 3;
    localparam int BUTTON_W = 2;
    localparam int PEND_W   = 5;
    localparam int DROP_W   = 2;
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_POP    = 1'b1
    } cmd_t;

    typedef logic [CHANNELS-1:0] chan_vec_t;

    typedef struct packed
    {
        logic [BUTTON_W-1:0] button;
        logic                pressed;
    } event_t;

endpackage

@@ src/bdef_in_if.sv @@
interface bdef_in_if;

    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [bdef_pkg::TIME_W-1:0]      now_ms;
    logic [bdef_pkg::PIN_W-1:0]       pin_levels;

    modport source (output valid, output cmd, output now_ms, output pin_levels, input ready);
    modport sink   (input valid, input cmd, input now_ms, input pin_levels, output ready);

endinterface

@@ src/bdef_out_if.sv @@
interface bdef_out_if;

    logic                             valid;
    logic                             ready;
    logic                             event_valid;
    logic [bdef_pkg::BUTTON_W-1:0]    event_button;
    logic                             event_pressed;
    logic [bdef_pkg::PEND_W-1:0]      pending;
    logic [bdef_pkg::DROP_W-1:0]      dropped;

    modport source (output valid, output event_valid, output event_button,
                    output event_pressed, output pending, output dropped, input ready);
    modport sink   (input valid, input event_valid, input event_button,
                    input event_pressed, input pending, input dropped, output ready);

endinterface

@@ src/button_debounce_event_fifo.sv @@
// Path: a word accepted on req goes to the input register, then its result to
// the result register, which drives rsp; a stall on rsp can hold both.
// Throughput: one word per cycle while rsp is ready; input and result registers
// are separately handshaked; a word enters while a result waits if s1 is free.
// Reset (rst_n, async, active low): buttons released, agree times zero,
// queue empty, debounce threshold 50 ms. Queue contents are not cleared.
module button_debounce_event_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    bdef_in_if.sink                       req,
    bdef_out_if.source                    rsp,
    input  logic                          cfg_wr_en,
    input  logic [bdef_pkg::CFG_W-1:0]    cfg_wr_data
);

    localparam int CH  = bdef_pkg::CHANNELS;
    localparam int QD  = bdef_pkg::QUEUE_DEPTH;
    localparam int PW  = bdef_pkg::PTR_W;
    localparam int CW  = bdef_pkg::CNT_W;
    localparam int TW  = bdef_pkg::TIME_W;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(QD - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    logic [bdef_pkg::CFG_W-1:0]    debounce_reg;

    logic                          s1_valid_reg;
    logic                          s1_cmd_reg;
    logic [TW-1:0]                 s1_now_reg;
    logic [bdef_pkg::PIN_W-1:0]    s1_pins_reg;

    logic [CH-1:0]                 acc_reg;
    logic [CH-1:0]                 acc_next;
    logic [TW-1:0]                 agree_reg  [CH];
    logic [TW-1:0]                 agree_next [CH];

    bdef_pkg::event_t              store_reg [QD];
    logic [PW-1:0]                 rd_ptr_reg;
    logic [PW-1:0]                 rd_ptr_next;
    logic [PW-1:0]                 wr_ptr_reg;
    logic [PW-1:0]                 wr_ptr_next;
    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 fill_next;

    logic                          out_valid_reg;
    logic                          out_ev_valid_reg;
    bdef_pkg::event_t              out_ev_reg;
    logic [bdef_pkg::PEND_W-1:0]   out_pending_reg;
    logic [bdef_pkg::DROP_W-1:0]   out_dropped_reg;

    logic                          s2_ready;
    logic                          s1_fire;
    logic                          in_fire;

    logic [CH-1:0]                 we;
    logic [PW-1:0]                 waddr [CH];
    bdef_pkg::event_t              wdata [CH];
    logic [bdef_pkg::LOST_W-1:0]   lost;
    logic                          ev_valid;
    bdef_pkg::chan_vec_t           pins_ext;
    logic                          level;
    logic [TW-1:0]                 elapsed;

    assign s2_ready  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign req.ready = !s1_valid_reg || s2_ready;
    assign in_fire   = req.valid && req.ready;

    // absent pins (more channels than pins) read as pressed
    assign pins_ext = bdef_pkg::chan_vec_t'(s1_pins_reg);

    always_comb
    begin
        acc_next    = acc_reg;
        agree_next  = agree_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        we          = '0;
        lost        = '0;
        ev_valid    = 1'b0;
        level       = 1'b0;
        elapsed     = '0;
        for (int ch = 0; ch < CH; ch++)
        begin
            waddr[ch] = '0;
            wdata[ch] = '0;
        end
        if (s1_cmd_reg == bdef_pkg::CMD_SAMPLE)
        begin
            for (int ch = 0; ch < CH; ch++)
            begin
                level   = !pins_ext[ch];
                elapsed = s1_now_reg - agree_reg[ch];
                if (level == acc_reg[ch])
                begin
                    agree_next[ch] = s1_now_reg;
                end
                else if (elapsed >= TW'(debounce_reg))
                begin
                    acc_next[ch]   = level;
                    agree_next[ch] = s1_now_reg;
                    if (fill_next < CW'(QD))
                    begin
                        we[ch]            = 1'b1;
                        waddr[ch]         = wr_ptr_next;
                        wdata[ch].button  = bdef_pkg::BUTTON_W'(ch);
                        wdata[ch].pressed = level;
                        wr_ptr_next       = next_ptr(wr_ptr_next);
                        fill_next         = fill_next + CW'(1);
                    end
                    else
                    begin
                        lost = lost + bdef_pkg::LOST_W'(1);
                    end
                end
            end
        end
        else if (fill_reg != '0)
        begin
            ev_valid    = 1'b1;
            rd_ptr_next = next_ptr(rd_ptr_reg);
            fill_next   = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= bdef_pkg::DEBOUNCE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            for (int ch = 0; ch < CH; ch++)
            begin
                agree_reg[ch] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_reg <= cfg_wr_data;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                acc_reg    <= acc_next;
                agree_reg  <= agree_next;
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                fill_reg   <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_now_reg  <= req.now_ms;
            s1_pins_reg <= req.pin_levels;
        end
        if (s1_fire)
        begin
            out_ev_valid_reg <= ev_valid;
            out_ev_reg       <= ev_valid ? store_reg[rd_ptr_reg] : '0;
            out_pending_reg  <= bdef_pkg::PEND_W'(fill_next);
            out_dropped_reg  <= bdef_pkg::DROP_W'(lost);
            for (int ch = 0; ch < CH; ch++)
            begin
                if (we[ch])
                begin
                    store_reg[waddr[ch]] <= wdata[ch];
                end
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.event_valid   = out_ev_valid_reg;
    assign rsp.event_button  = out_ev_reg.button;
    assign rsp.event_pressed = out_ev_reg.pressed;
    assign rsp.pending       = out_pending_reg;
    assign rsp.dropped       = out_dropped_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(QD))
        else $error("queue fill count exceeds depth");

    a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0 || fill_reg == CW'(QD)) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers disagree with fill count");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && lost != '0) |-> (fill_next == CW'(QD)))
        else $error("event dropped while queue had room");

    a_drop_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dropped_reg != '0) |-> !out_ev_valid_reg)
        else $error("dropped count on a pop result");

endmodule
